// File: sv/swsr_pkg.sv
// Shared types, codes and timing windows for the single-wire sensor reader.
`default_nettype none

package swsr_pkg;

    // Queue depths
    localparam int IN_Q_DEPTH_DEF  = 2;
    localparam int OUT_Q_DEPTH_DEF = 2;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_LOW_TICKS   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_ONE_THRESHOLD = 1'd1;
    localparam logic [15:0] START_LOW_TICKS_RST   = 16'd20000;
    localparam logic [7:0]  BIT_ONE_THRESHOLD_RST = 8'd48;

    // Phase timing
    localparam int TICK_W = 16;
    localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;
    localparam logic [TICK_W-1:0] REL_MIN   = 16'd10;
    localparam logic [TICK_W-1:0] REL_MAX   = 16'd35;
    localparam logic [TICK_W-1:0] RLOW_MIN  = 16'd78;
    localparam logic [TICK_W-1:0] RLOW_MAX  = 16'd88;
    localparam logic [TICK_W-1:0] RHIGH_MIN = 16'd80;
    localparam logic [TICK_W-1:0] RHIGH_MAX = 16'd92;
    localparam logic [TICK_W-1:0] BLOW_MIN  = 16'd48;
    localparam logic [TICK_W-1:0] BLOW_MAX  = 16'd58;
    localparam logic [TICK_W-1:0] BHIGH_MIN = 16'd23;
    localparam logic [TICK_W-1:0] BHIGH_MAX = 16'd74;

    localparam int FRAME_W = 40;
    localparam logic [5:0] FRAME_BITS = 6'd40;
    localparam logic [6:0] TENTHS_MASK = 7'h7F;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RELEASE  = 3'd1;
    localparam logic [2:0] ST_RESP_LOW = 3'd2;
    localparam logic [2:0] ST_RESP_HI  = 3'd3;
    localparam logic [2:0] ST_BIT_LOW  = 3'd4;
    localparam logic [2:0] ST_BIT_HI   = 3'd5;
    localparam logic [2:0] ST_CHECKSUM = 3'd6;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_REL   = 3'd2,
        PH_RLOW  = 3'd3,
        PH_RHIGH = 3'd4,
        PH_BLOW  = 3'd5,
        PH_BHIGH = 3'd6
    } phase_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } op_t;

    typedef struct packed {
        logic req_type;
        logic pin_level;
    } req_t;

    typedef struct packed {
        op_t  op;
        logic pin_level;
    } cmd_t;

    typedef struct packed {
        logic               line_drive_low;
        logic               busy_res;
        logic               done_res;
        logic [2:0]         status;
        logic [7:0]         humidity;
        logic [7:0]         humidity_fraction;
        logic signed [12:0] temperature_tenths;
    } res_t;

endpackage

`default_nettype wire

// File: sv/swsr_front.sv
// Front end: input queue that classifies each beat into a tick or a start command.
`default_nettype none

module swsr_front #(
    parameter int DEPTH = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire swsr_pkg::req_t req_item,
    input  wire logic          push,
    output logic               full,
    output swsr_pkg::cmd_t     cmd,
    output logic               cmd_valid,
    input  wire logic          cmd_pop
);
    import swsr_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;
    cmd_t             cmd_in;

    assign full      = (cnt_reg == CNT_FULL);
    assign cmd_valid = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;
    assign cmd       = mem[rd_ptr_reg];

    always_comb
    begin
        cmd_in.op        = req_item.req_type ? OP_START : OP_TICK;
        cmd_in.pin_level = req_item.pin_level;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// File: sv/swsr_engine.sv
// Back end: phase sequencer, phase timers, bit assembly and frame check.
`default_nettype none

module swsr_engine (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [swsr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [swsr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire swsr_pkg::cmd_t                    cmd,
    input  wire logic                              fire,
    output swsr_pkg::res_t                         res
);
    import swsr_pkg::*;

    phase_t              ph_reg, ph_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [5:0]          bit_reg, bit_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;
    logic [2:0]          status_reg, status_next;
    logic [7:0]          hum_reg, hum_next;
    logic [7:0]          frac_reg, frac_next;
    logic signed [12:0]  temp_reg, temp_next;
    logic [15:0]         start_low_reg;
    logic [7:0]          thr_reg;
    logic                done;

    logic [TICK_W-1:0]   cnt_inc;
    logic [TICK_W-1:0]   win_lo, win_hi;
    logic                win_level;
    logic [2:0]          win_code;
    phase_t              win_after;
    logic                lvl_same, tm_err, tm_end, start_end;
    logic                bit_val, last_bit;
    logic [5:0]          bit_inc;
    logic [FRAME_W-1:0]  frame_shifted;
    logic [7:0]          b0, b1, b2, b3, b4, sum;
    logic                csum_ok;
    logic [12:0]         tmag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_low_reg <= START_LOW_TICKS_RST;
            thr_reg       <= BIT_ONE_THRESHOLD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_LOW_TICKS:   start_low_reg <= cfg_data;
                CFG_BIT_ONE_THRESHOLD: thr_reg       <= cfg_data[7:0];
                default:               ;
            endcase
        end
    end

    // Window of the current timed phase
    always_comb
    begin
        win_lo    = REL_MIN;
        win_hi    = REL_MAX;
        win_level = 1'b1;
        win_code  = ST_RELEASE;
        win_after = PH_RLOW;
        case (ph_reg)
            PH_RLOW:
            begin
                win_lo    = RLOW_MIN;
                win_hi    = RLOW_MAX;
                win_level = 1'b0;
                win_code  = ST_RESP_LOW;
                win_after = PH_RHIGH;
            end
            PH_RHIGH:
            begin
                win_lo    = RHIGH_MIN;
                win_hi    = RHIGH_MAX;
                win_level = 1'b1;
                win_code  = ST_RESP_HI;
                win_after = PH_BLOW;
            end
            PH_BLOW:
            begin
                win_lo    = BLOW_MIN;
                win_hi    = BLOW_MAX;
                win_level = 1'b0;
                win_code  = ST_BIT_LOW;
                win_after = PH_BHIGH;
            end
            PH_BHIGH:
            begin
                win_lo    = BHIGH_MIN;
                win_hi    = BHIGH_MAX;
                win_level = 1'b1;
                win_code  = ST_BIT_HI;
                win_after = PH_BLOW;
            end
            default: ;
        endcase
    end

    assign cnt_inc   = (tick_reg != TICK_MAX) ? tick_reg + 1'b1 : tick_reg;
    assign start_end = (cnt_inc >= start_low_reg);
    assign lvl_same  = (cmd.pin_level == win_level);
    assign tm_err    = lvl_same ? (cnt_inc > win_hi) : ((cnt_inc < win_lo) || (cnt_inc > win_hi));
    assign tm_end    = !lvl_same && !tm_err;

    assign bit_val       = (cnt_inc >= {8'd0, thr_reg});
    assign frame_shifted = {frame_reg[FRAME_W-2:0], bit_val};
    assign bit_inc       = bit_reg + 1'b1;
    assign last_bit      = (bit_inc >= FRAME_BITS);

    assign b0 = frame_shifted[39:32];
    assign b1 = frame_shifted[31:24];
    assign b2 = frame_shifted[23:16];
    assign b3 = frame_shifted[15:8];
    assign b4 = frame_shifted[7:0];
    assign sum     = b0 + b1 + b2 + b3;
    assign csum_ok = (sum == b4);
    // b2 * 10 as two shifts, plus the tenths in b3[6:0]
    assign tmag = {2'b00, b2, 3'b000} + {4'b0000, b2, 1'b0} + {6'd0, (b3[6:0] & TENTHS_MASK)};

    // Next phase
    always_comb
    begin
        ph_next = ph_reg;
        if (fire)
        begin
            if (cmd.op == OP_START)
            begin
                ph_next = PH_START;
            end
            else
            begin
                case (ph_reg)
                    PH_IDLE:  ph_next = PH_IDLE;
                    PH_START: ph_next = start_end ? PH_REL : PH_START;
                    PH_REL, PH_RLOW, PH_RHIGH, PH_BLOW:
                    begin
                        if (tm_err)
                        begin
                            ph_next = PH_IDLE;
                        end
                        else if (tm_end)
                        begin
                            ph_next = win_after;
                        end
                    end
                    PH_BHIGH:
                    begin
                        if (tm_err || (tm_end && last_bit))
                        begin
                            ph_next = PH_IDLE;
                        end
                        else if (tm_end)
                        begin
                            ph_next = PH_BLOW;
                        end
                    end
                    default:  ph_next = PH_IDLE;
                endcase
            end
        end
    end

    // Counters, frame and held results
    always_comb
    begin
        tick_next   = tick_reg;
        bit_next    = bit_reg;
        frame_next  = frame_reg;
        status_next = status_reg;
        hum_next    = hum_reg;
        frac_next   = frac_reg;
        temp_next   = temp_reg;
        done        = 1'b0;
        if (fire)
        begin
            if (cmd.op == OP_START)
            begin
                tick_next  = '0;
                bit_next   = '0;
                frame_next = '0;
            end
            else
            begin
                case (ph_reg)
                    PH_IDLE: ;
                    PH_START:
                    begin
                        tick_next = start_end ? '0 : cnt_inc;
                    end
                    PH_REL, PH_RLOW, PH_RHIGH, PH_BLOW, PH_BHIGH:
                    begin
                        tick_next = cnt_inc;
                        if (tm_err)
                        begin
                            tick_next   = '0;
                            status_next = win_code;
                            done        = 1'b1;
                        end
                        else if (tm_end)
                        begin
                            tick_next = '0;
                            if (ph_reg == PH_BHIGH)
                            begin
                                frame_next = frame_shifted;
                                bit_next   = bit_inc;
                                if (last_bit)
                                begin
                                    done = 1'b1;
                                    if (csum_ok)
                                    begin
                                        status_next = ST_OK;
                                        hum_next    = b0;
                                        frac_next   = b1;
                                        temp_next   = b3[7] ? -$signed(tmag) : $signed(tmag);
                                    end
                                    else
                                    begin
                                        status_next = ST_CHECKSUM;
                                    end
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg     <= PH_IDLE;
            tick_reg   <= '0;
            bit_reg    <= '0;
            frame_reg  <= '0;
            status_reg <= ST_OK;
            hum_reg    <= '0;
            frac_reg   <= '0;
            temp_reg   <= '0;
        end
        else
        begin
            ph_reg     <= ph_next;
            tick_reg   <= tick_next;
            bit_reg    <= bit_next;
            frame_reg  <= frame_next;
            status_reg <= status_next;
            hum_reg    <= hum_next;
            frac_reg   <= frac_next;
            temp_reg   <= temp_next;
        end
    end

    always_comb
    begin
        res.line_drive_low     = (ph_next == PH_START);
        res.busy_res           = (ph_next != PH_IDLE);
        res.done_res           = done;
        res.status             = status_next;
        res.humidity           = hum_next;
        res.humidity_fraction  = frac_next;
        res.temperature_tenths = temp_next;
    end

endmodule

`default_nettype wire

// File: sv/swsr_res_q.sv
// Result queue between the engine and the consumer.
`default_nettype none

module swsr_res_q #(
    parameter int DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire swsr_pkg::res_t res_in,
    input  wire logic           res_push,
    output logic                res_full,
    output swsr_pkg::res_t      res_item,
    output logic                empty,
    input  wire logic           pop
);
    import swsr_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    res_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign res_full = (cnt_reg == CNT_FULL);
    assign empty    = (cnt_reg == '0);
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;
    assign res_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= res_in;
        end
    end

endmodule

`default_nettype wire

// File: sv/single_wire_sensor_reader_top.sv
// Top level of the single-wire sensor reader: front queue, engine, result queue.
`default_nettype none

// Single-wire temperature/humidity sensor receiver. Push one beat per microsecond
// tick with the sampled line level, or a start beat to begin a reading; every beat
// yields exactly one result beat with the line drive, busy, done, status and the last
// good humidity and temperature. While the result queue has room, the block sustains
// one beat per clock: the engine handles one command per cycle and writes its result
// into the result queue, so a result passes the input and then the result queue
// registers before it shows on the result ports. A full result queue holds the engine,
// and the input queue then fills and raises full. Write the configuration only while
// no beat is in flight. IN_Q_DEPTH and OUT_Q_DEPTH (at least 2) size the two queues.
module single_wire_sensor_reader_top #(
    parameter int IN_Q_DEPTH  = swsr_pkg::IN_Q_DEPTH_DEF,
    parameter int OUT_Q_DEPTH = swsr_pkg::OUT_Q_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire swsr_pkg::req_t                    req_item,
    input  wire logic                              push,
    output logic                                   full,
    output swsr_pkg::res_t                         res_item,
    output logic                                   empty,
    input  wire logic                              pop,
    input  wire logic                              cfg_we,
    input  wire logic [swsr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [swsr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import swsr_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic res_full;
    logic fire;
    res_t eng_res;

    // Advance the engine only when the result queue can take the beat
    assign fire = cmd_valid && !res_full;

    swsr_front #(
        .DEPTH (IN_Q_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (fire)
    );

    swsr_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .fire      (fire),
        .res       (eng_res)
    );

    swsr_res_q #(
        .DEPTH (OUT_Q_DEPTH)
    ) u_res_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_in   (eng_res),
        .res_push (fire),
        .res_full (res_full),
        .res_item (res_item),
        .empty    (empty),
        .pop      (pop)
    );

    a_drive_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && res_item.line_drive_low |-> res_item.busy_res)
        else $error("line driven low while not busy");

    a_done_ends_reading: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && res_item.done_res |-> !res_item.busy_res && !res_item.line_drive_low)
        else $error("done beat still busy");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> res_item.status <= ST_CHECKSUM)
        else $error("status code out of range");

    a_start_drives: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cmd.op == OP_START |-> eng_res.line_drive_low && eng_res.busy_res
            && !eng_res.done_res)
        else $error("start command does not drive the line low");

endmodule

`default_nettype wire
